>>> rtl/alle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alle_pkg
// Shared sizes, command codes, status codes and the cell link and control types
// of the linked list engine.
// ----------------------------------------------------------------------------
package alle_pkg;

  localparam int SLOTS = 256;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int CMD_W = 2;
  localparam int POS_W = 9;
  localparam int VAL_W = 32;
  localparam int ST_W  = 3;
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [ST_W-1:0] ST_BADPOS   = 3'd3;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

  // token handed from a cell to its right neighbor
  typedef struct packed {
    logic             tok;
    logic [VAL_W-1:0] carry;
  } tok_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic             run;
    logic [CMD_W-1:0] op;
    logic             shift;
    logic             cont;
    logic [VAL_W-1:0] key;
  } ctrl_t;

endpackage

>>> rtl/alle_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alle_cmd_if / alle_rsp_if
// Valid/ready channels for list commands and their results.
// ----------------------------------------------------------------------------
interface alle_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [alle_pkg::CMD_W-1:0]       cmd;
  logic [alle_pkg::POS_W-1:0]       position;
  logic signed [alle_pkg::VAL_W-1:0] value;

  modport source (output valid, cmd, position, value, input ready);
  modport sink (input valid, cmd, position, value, output ready);
endinterface

interface alle_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [alle_pkg::ST_W-1:0]  status;
  logic [alle_pkg::POS_W-1:0] found_position;
  logic [alle_pkg::POS_W-1:0] list_length;

  modport source (output valid, status, found_position, list_length, input ready);
  modport sink (input valid, status, found_position, list_length, output ready);
endinterface

>>> rtl/alle_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alle_cell
// One list node: holds one item, takes the token from the left neighbor,
// shifts items right on insert, pulls from the right neighbor on delete and
// compares against the key on search.
// ----------------------------------------------------------------------------
module alle_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  alle_pkg::ctrl_t            ctrl,
  input  alle_pkg::tok_t             tin,
  input  logic [alle_pkg::VAL_W-1:0] right_data,
  output alle_pkg::tok_t             tout,
  output logic [alle_pkg::VAL_W-1:0] data,
  output logic                       hit
);

  logic active;
  logic ins_shift;
  logic del_shift;

  assign active    = ctrl.run & tin.tok;
  assign ins_shift = active & ctrl.shift & (ctrl.op == alle_pkg::CMD_INSERT);
  assign del_shift = active & ctrl.shift & (ctrl.op == alle_pkg::CMD_DELETE);
  assign hit       = active & (data == ctrl.key);

  always_ff @(posedge clk) begin
    if (rst) begin
      tout.tok <= 1'b0;
    end else begin
      tout.tok <= active & ctrl.cont;
    end
    tout.carry <= ins_shift ? data : tin.carry;
    if (ins_shift) begin
      data <= tin.carry;
    end else if (del_shift) begin
      data <= right_data;
    end
  end

endmodule

>>> rtl/array_linked_list_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_linked_list_engine_unit
// Ordered list of up to SLOTS items held in a row of cells; a token walks
// from the head cell to do insert, delete and search.
//
//   channel | dir | fields
//   req     | in  | cmd, position, value
//   rsp     | out | status, found_position, list_length
//
// One command at a time. A token enters cell 0 in the cycle after accept and
// moves one cell per cycle: insert walks to the cell after the last item,
// delete to the last item, and search stops at the first hit. Rejected and
// unused commands skip the walk. The result then moves into the output
// register once it is free. Reset is synchronous and leaves the list empty at once;
// no clearing pass. A new command is taken while the last result waits.
// ----------------------------------------------------------------------------
module array_linked_list_engine_unit (
  input  logic        clk,
  input  logic        rst,
  alle_cmd_if.sink    req,
  alle_rsp_if.source  rsp
);

  localparam int SL = alle_pkg::SLOTS;
  localparam int IW = alle_pkg::IDX_W;
  localparam int NW = alle_pkg::CNT_W;
  localparam int CW = alle_pkg::CMP_W;
  localparam int PW = alle_pkg::POS_W;
  localparam int VW = alle_pkg::VAL_W;
  localparam int SW = alle_pkg::ST_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0]                state;
  logic [alle_pkg::CMD_W-1:0] op;
  logic [CW-1:0]             pos;
  logic [VW-1:0]             key;
  logic [IW-1:0]             idx;
  logic [NW-1:0]             count;
  logic                      launch;
  logic [SW-1:0]             pend_status;
  logic [PW-1:0]             pend_found;
  logic [PW-1:0]             pend_len;
  logic                      rsp_valid;
  logic [SW-1:0]             rsp_status;
  logic [PW-1:0]             rsp_found;
  logic [PW-1:0]             rsp_len;

  alle_pkg::tok_t            link [SL+1];
  logic [VW-1:0]             data_row [SL+1];
  logic [SL-1:0]             hit_row;
  alle_pkg::ctrl_t           ctrl;

  logic                      accept;
  logic [CW-1:0]             req_pos;
  logic [CW-1:0]             cnt_x;
  logic [CW-1:0]             idx_x;
  logic                      reject;
  logic [SW-1:0]             rej_status;
  logic                      hit_any;
  logic                      finish;

  assign accept  = req.valid & req.ready;
  assign req_pos = CW'(req.position);
  assign cnt_x   = CW'(count);
  assign idx_x   = CW'(idx);
  assign hit_any = |hit_row;

  always_comb begin
    reject     = 1'b1;
    rej_status = alle_pkg::ST_OK;
    case (req.cmd)
      alle_pkg::CMD_INSERT: begin
        if (count == NW'(SL)) begin
          rej_status = alle_pkg::ST_FULL;
        end else if (req_pos == '0 || req_pos > cnt_x + CW'(1)) begin
          rej_status = alle_pkg::ST_BADPOS;
        end else begin
          reject = 1'b0;
        end
      end
      alle_pkg::CMD_DELETE: begin
        if (count == '0) begin
          rej_status = alle_pkg::ST_EMPTY;
        end else if (req_pos == '0 || req_pos > cnt_x) begin
          rej_status = alle_pkg::ST_BADPOS;
        end else begin
          reject = 1'b0;
        end
      end
      alle_pkg::CMD_SEARCH: begin
        if (count == '0) begin
          rej_status = alle_pkg::ST_NOTFOUND;
        end else begin
          reject = 1'b0;
        end
      end
      default: begin
        reject = 1'b1;
      end
    endcase
  end

  always_comb begin
    case (op)
      alle_pkg::CMD_INSERT: finish = (idx_x == cnt_x);
      default:              finish = (idx_x + CW'(1) == cnt_x);
    endcase
  end

  assign ctrl.run   = (state == S_RUN);
  assign ctrl.op    = op;
  assign ctrl.shift = (idx_x + CW'(1) >= pos);
  assign ctrl.cont  = ~finish & ~((op == alle_pkg::CMD_SEARCH) & hit_any);
  assign ctrl.key   = key;

  assign link[0].tok   = launch;
  assign link[0].carry = key;
  assign data_row[SL]  = '0;

  for (genvar i = 0; i < SL; i++) begin : g_cell
    alle_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .tin        (link[i]),
      .right_data (data_row[i+1]),
      .tout       (link[i+1]),
      .data       (data_row[i]),
      .hit        (hit_row[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      launch <= 1'b0;
    end else begin
      launch <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            op  <= req.cmd;
            pos <= req_pos;
            key <= VW'(req.value);
            idx <= '0;
            if (reject) begin
              pend_status <= rej_status;
              pend_found  <= '0;
              pend_len    <= PW'(count);
              state       <= S_HOLD;
            end else begin
              launch <= 1'b1;
              state  <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (op == alle_pkg::CMD_SEARCH && hit_any) begin
            pend_status <= alle_pkg::ST_OK;
            pend_found  <= PW'(idx_x + CW'(1));
            pend_len    <= PW'(count);
            state       <= S_HOLD;
          end else if (finish) begin
            pend_found <= '0;
            state      <= S_HOLD;
            case (op)
              alle_pkg::CMD_INSERT: begin
                pend_status <= alle_pkg::ST_OK;
                count       <= count + NW'(1);
                pend_len    <= PW'(count + NW'(1));
              end
              alle_pkg::CMD_DELETE: begin
                pend_status <= alle_pkg::ST_OK;
                count       <= count - NW'(1);
                pend_len    <= PW'(count - NW'(1));
              end
              default: begin
                pend_status <= alle_pkg::ST_NOTFOUND;
                pend_len    <= PW'(count);
              end
            endcase
          end else begin
            idx <= idx + IW'(1);
          end
        end
        S_HOLD: begin
          if (!rsp_valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_HOLD && (!rsp_valid || rsp.ready)) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_HOLD && (!rsp_valid || rsp.ready)) begin
      rsp_status <= pend_status;
      rsp_found  <= pend_found;
      rsp_len    <= pend_len;
    end
  end

  assign req.ready          = (state == S_IDLE);
  assign rsp.valid          = rsp_valid;
  assign rsp.status         = rsp_status;
  assign rsp.found_position = rsp_found;
  assign rsp.list_length    = rsp_len;

endmodule
